// File: hdl/lpgw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgw_pkg
// Shared types, command codes and the 5x7 font table of the pixel and glyph
// writer.
// ----------------------------------------------------------------------------
package lpgw_pkg;

  // input item and result item
  typedef struct packed {
    logic [1:0] action;
    logic [6:0] column;
    logic [5:0] row;
    logic [1:0] draw_op;
    logic [2:0] text_page;
    logic [7:0] char_code;
  } lpgw_in_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } lpgw_out_t;

  // actions
  localparam logic [1:0] ACT_PIXEL    = 2'd0;
  localparam logic [1:0] ACT_TEXT_POS = 2'd1;
  localparam logic [1:0] ACT_CHAR     = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  // pixel operations
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_KEEP   = 2'd3;

  // controller command bytes
  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // index of the final byte of each run
  localparam logic [2:0] PIX_LAST  = 3'd3;
  localparam logic [2:0] POS_LAST  = 3'd2;
  localparam logic [2:0] CHAR_LAST = 3'd5;

  // font geometry
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam int         GLYPH_COUNT = 99;
  localparam logic [2:0] GLYPH_W     = 3'd5;

  // what the shared byte unit forms in one step
  typedef enum logic [2:0] {
    BK_PAGE   = 3'd0,
    BK_COL_HI = 3'd1,
    BK_COL_LO = 3'd2,
    BK_PIXEL  = 3'd3,
    BK_GLYPH  = 3'd4
  } lpgw_kind_t;

  typedef struct packed {
    lpgw_kind_t kind;
    logic [3:0] page;
    logic [6:0] column;
    logic [2:0] bit_sel;
    logic [1:0] draw_op;
    logic [6:0] glyph;
    logic       glyph_ok;
    logic [2:0] glyph_col;
  } lpgw_req_t;

  typedef struct packed {
    logic valid;
    logic is_data;
    logic last;
  } lpgw_emit_t;

  // one row per glyph, leftmost column in the top byte, bit 0 is the top pixel
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552240, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h020151093E,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149493A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4070403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F44444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4020403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0C041C1018, 40'h0000000000,
    40'h08082A1C08, 40'h081C2A0808, 40'h0705070000
  };

endpackage

// File: hdl/lpgw_frame_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgw_frame_ram
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpgw_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lpgw_byte_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgw_byte_unit
// Shared byte former: command bytes, pixel read-modify-write and glyph columns.
// ----------------------------------------------------------------------------
module lpgw_byte_unit
  import lpgw_pkg::*;
(
  input  lpgw_req_t  req,
  input  logic [7:0] rdata,
  output logic [7:0] result
);

  logic [7:0]  mask;
  logic [39:0] glyph_row;
  logic [39:0] glyph_sh;
  logic [2:0]  col_from_right;

  always_comb begin
    mask           = 8'(1) << req.bit_sel;
    glyph_row      = req.glyph_ok ? FONT_ROM[req.glyph] : '0;
    col_from_right = (GLYPH_W - 3'd1) - req.glyph_col;
    glyph_sh       = glyph_row >> {col_from_right, 3'b000};
    result         = '0;
    case (req.kind)
      BK_PAGE:   result = CMD_PAGE | ({4'h0, req.page} & NIBBLE_MASK);
      BK_COL_HI: result = CMD_COL_HI | {5'h0, req.column[6:4]};
      BK_COL_LO: result = {4'h0, req.column[3:0]};
      BK_PIXEL: begin
        case (req.draw_op)
          OP_CLEAR:  result = rdata & ~mask;
          OP_SET:    result = rdata | mask;
          OP_TOGGLE: result = rdata ^ mask;
          OP_KEEP:   result = rdata;
          default:   result = rdata;
        endcase
      end
      BK_GLYPH: begin
        // sixth column is the blank spacer
        if (req.glyph_ok && (req.glyph_col < GLYPH_W)) begin
          result = glyph_sh[7:0];
        end
      end
      default: result = '0;
    endcase
  end

endmodule

// File: hdl/lpgw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpgw_seq
// Command sequencer: clearing pass, text pointer and byte-by-byte stepping.
// ----------------------------------------------------------------------------
module lpgw_seq
  import lpgw_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int DEPTH   = 1024,
  parameter int AW      = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  lpgw_in_t      in_item,
  output logic          ready,
  input  logic          emit_free,
  output lpgw_emit_t    emit,
  output lpgw_req_t     req,
  input  logic [7:0]    result,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EMIT  = 3'b100
  } lpgw_state_t;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [8:0]    COL_K     = 9'(COLUMNS);
  localparam logic [4:0]    PAGE_K    = 5'(PAGES);

  lpgw_state_t   state_r, state_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]    act_r, act_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [3:0]    page_r, page_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [6:0]    glyph_r, glyph_nxt;
  logic          gok_r, gok_nxt;
  logic [AW-1:0] pix_addr_r, pix_addr_nxt;

  logic [8:0]  col_w;
  logic [4:0]  page_w;
  logic [6:0]  col_red;
  logic [3:0]  page_red;
  logic [12:0] idx_w;
  logic [7:0]  glyph_off;
  logic        glyph_known;
  logic        is_last;
  logic        is_char;
  logic        is_pix_data;

  // reduce column and page by repeated subtraction, values stay narrow
  always_comb begin
    col_w = {2'b00, in_item.column};
    for (int i = 0; i < 8; i++) begin
      if (col_w >= COL_K) begin
        col_w = col_w - COL_K;
      end
    end
    page_w = (in_item.action == ACT_PIXEL) ? {2'b00, in_item.row[5:3]}
                                           : {2'b00, in_item.text_page};
    for (int i = 0; i < 8; i++) begin
      if (page_w >= PAGE_K) begin
        page_w = page_w - PAGE_K;
      end
    end
    col_red     = col_w[6:0];
    page_red    = page_w[3:0];
    idx_w       = 13'(page_red) * 13'(COLUMNS) + 13'(col_red);
    glyph_off   = in_item.char_code - GLYPH_FIRST;
    glyph_known = (in_item.char_code >= GLYPH_FIRST) &&
                  (glyph_off < 8'(GLYPH_COUNT));
  end

  assign is_char     = (act_r == ACT_CHAR);
  assign is_pix_data = (act_r == ACT_PIXEL) && (step_r == PIX_LAST);

  always_comb begin
    case (act_r)
      ACT_PIXEL:    is_last = (step_r == PIX_LAST);
      ACT_TEXT_POS: is_last = (step_r == POS_LAST);
      ACT_CHAR:     is_last = (step_r == CHAR_LAST);
      default:      is_last = 1'b1;
    endcase
  end

  // byte request for the current step
  always_comb begin
    req.page      = page_r;
    req.column    = col_r;
    req.bit_sel   = bit_r;
    req.draw_op   = op_r;
    req.glyph     = glyph_r;
    req.glyph_ok  = gok_r;
    req.glyph_col = step_r;
    if (is_char) begin
      req.kind = BK_GLYPH;
    end else begin
      case (step_r)
        3'd0:    req.kind = BK_PAGE;
        3'd1:    req.kind = BK_COL_HI;
        3'd2:    req.kind = BK_COL_LO;
        default: req.kind = BK_PIXEL;
      endcase
    end
  end

  assign ready        = (state_r == ST_IDLE);
  assign emit.valid   = (state_r == ST_EMIT);
  assign emit.is_data = is_char || is_pix_data;
  assign emit.last    = is_last;
  assign mem_raddr    = idx_w[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    clr_nxt      = clr_r;
    ptr_nxt      = ptr_r;
    act_nxt      = act_r;
    col_nxt      = col_r;
    page_nxt     = page_r;
    bit_nxt      = bit_r;
    op_nxt       = op_r;
    glyph_nxt    = glyph_r;
    gok_nxt      = gok_r;
    pix_addr_nxt = pix_addr_r;
    mem_we       = 1'b0;
    mem_waddr    = ptr_r;
    mem_wdata    = result;
    mem_re       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_item.action;
          col_nxt      = col_red;
          page_nxt     = page_red;
          bit_nxt      = in_item.row[2:0];
          op_nxt       = in_item.draw_op;
          glyph_nxt    = glyph_off[6:0];
          gok_nxt      = glyph_known;
          pix_addr_nxt = idx_w[AW-1:0];
          step_nxt     = '0;
          case (in_item.action)
            ACT_PIXEL: begin
              // frame byte is read now, ready by the data step
              mem_re    = 1'b1;
              state_nxt = ST_EMIT;
            end
            ACT_TEXT_POS: begin
              ptr_nxt   = idx_w[AW-1:0];
              state_nxt = ST_EMIT;
            end
            ACT_CHAR: begin
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (emit_free) begin
          if (is_char || is_pix_data) begin
            mem_we    = 1'b1;
            mem_waddr = is_char ? ptr_r : pix_addr_r;
          end
          if (is_char) begin
            ptr_nxt = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
      clr_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      clr_r   <= clr_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    col_r      <= col_nxt;
    page_r     <= page_nxt;
    bit_r      <= bit_nxt;
    op_r       <= op_nxt;
    glyph_r    <= glyph_nxt;
    gok_r      <= gok_nxt;
    pix_addr_r <= pix_addr_nxt;
  end

endmodule

// File: hdl/lcd_pixel_and_glyph_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_pixel_and_glyph_writer_unit
// Page-organized monochrome framebuffer with pixel, text position and 5x7
// character commands, emitting the display controller byte stream.
// ----------------------------------------------------------------------------
// After reset all COLUMNS*PAGES bytes of the frame store (1024 at the
// defaults) are swept to zero, one byte per cycle; in_stall stays high
// during the sweep. After that the block takes one command at a time and
// emits one byte per cycle while out_stall does not hold it back, through a
// single shared byte unit and one frame memory with one write and one read
// port. A pixel command emits 4 bytes, a text position command 3, a
// character 6 and an unused action none. The last byte of a command sits in
// the output register, so the next command is taken while that byte still
// waits on out_stall.
module lcd_pixel_and_glyph_writer_unit
  import lpgw_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lpgw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lpgw_out_t out_data
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic          seq_ready;
  logic          emit_free;
  logic          load;
  lpgw_emit_t    emit;
  lpgw_req_t     req;
  logic [7:0]    result;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic      out_valid_r, out_valid_nxt;
  lpgw_out_t out_data_r, out_data_nxt;

  lpgw_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lpgw_byte_unit u_byte (
    .req    (req),
    .rdata  (mem_rdata),
    .result (result)
  );

  lpgw_seq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .ready     (seq_ready),
    .emit_free (emit_free),
    .emit      (emit),
    .req       (req),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  assign in_stall  = !seq_ready;
  assign emit_free = !out_valid_r || !out_stall;
  assign load      = emit.valid && emit_free;

  // output register, refilled in the cycle its byte is transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.lcd_byte = result;
      out_data_nxt.is_data  = emit.is_data;
      out_data_nxt.last     = emit.last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the clearing sweep holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken before the frame store was cleared");

  // a real command starts emitting in the next cycle
  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.action != ACT_NONE)) |=> emit.valid)
    else $error("accepted command produced no byte");

  // the final byte of a run frees the input side
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (load && emit.last) |=> !in_stall)
    else $error("input still stalled after the last byte of a run");

  // the sequencer never emits while it is ready for a new command
  a_no_emit_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !emit.valid)
    else $error("byte emitted while idle");

endmodule
